// ----- rtl/core/crc_framed_packet_checker_core_defines.svh -----
// Assertion macros used by the framed packet checker assertion module.
// Depends on nothing; the using scope must provide clk and rst_n.
`ifndef CRC_FRAMED_PACKET_CHECKER_CORE_DEFINES_SVH
`define CRC_FRAMED_PACKET_CHECKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CFPC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfpc assertion failed");

// Next-cycle implication, disabled during reset
`define CFPC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfpc assertion failed");

`endif

// ----- rtl/core/cfpc_pkg.sv -----
// Types, constants and the CRC byte update for the framed packet checker.
// No dependencies; imported by the core and its checker.
`timescale 1ns / 1ps

package cfpc_pkg;

  // Request payload types
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_buffer;
  } in_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [15:0] payload_index;
    logic        frame_done;
    logic [2:0]  status;
    logic [7:0]  frame_opcode;
    logic [15:0] sequence_res;
    logic [31:0] timestamp_ms;
    logic [15:0] payload_length;
  } out_t;

  // Configuration register indexes
  localparam logic [2:0] REG_MAGIC_FIRST    = 3'd0;
  localparam logic [2:0] REG_MAGIC_SECOND   = 3'd1;
  localparam logic [2:0] REG_FORMAT_VERSION = 3'd2;
  localparam logic [2:0] REG_CRC_ENABLE     = 3'd3;
  localparam logic [2:0] REG_PAYLOAD_CAP    = 3'd4;
  localparam logic [2:0] REG_OPCODE_MASK    = 3'd5;

  // Verdict codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TRUNCATED   = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC   = 3'd2;
  localparam logic [2:0] ST_BAD_VERSION = 3'd3;
  localparam logic [2:0] ST_BAD_OPCODE  = 3'd4;
  localparam logic [2:0] ST_OVER_CAP    = 3'd5;
  localparam logic [2:0] ST_BAD_CRC     = 3'd6;

  // Header layout
  localparam logic [16:0] HDR_BYTES = 17'd12;
  localparam logic [16:0] HDR_LAST  = 17'd11;
  localparam logic [3:0] OFS_MAGIC0  = 4'd0;
  localparam logic [3:0] OFS_MAGIC1  = 4'd1;
  localparam logic [3:0] OFS_VERSION = 4'd2;
  localparam logic [3:0] OFS_OPCODE  = 4'd3;
  localparam logic [3:0] OFS_SEQ_LO  = 4'd4;
  localparam logic [3:0] OFS_SEQ_HI  = 4'd5;
  localparam logic [3:0] OFS_LEN_LO  = 4'd6;
  localparam logic [3:0] OFS_LEN_HI  = 4'd7;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // One byte through the MSB-first CRC shift register
  function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      x = x[15] ? ({x[14:0], 1'b0} ^ CRC_POLY) : {x[14:0], 1'b0};
    end
    return x;
  endfunction

endpackage

// ----- rtl/core/crc_framed_packet_checker_core.sv -----
// Framed packet checker core: header parse, payload pass-through, CRC verdict.
// Depends on cfpc_pkg.
//
//   channel  | direction | handshake          | carries
//   ---------+-----------+--------------------+-------------------------------
//   in_      | input     | in_valid / in_stall | one buffer byte and last mark
//   out_     | output    | out_valid/out_stall | payload byte and/or verdict
//   cfg_     | input     | cfg_valid/cfg_ready | register index and write data
//
// One byte is accepted per cycle while in_stall is low; any result it yields
// appears in the output register in the following cycle. in_stall rises only
// while a result sits in the output register and out_stall is high. Reset
// clears all frame state and loads register defaults; no clearing pass is
// needed. cfg_ready is always high.
`timescale 1ns / 1ps

module crc_framed_packet_checker_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cfpc_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cfpc_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data
);
  import cfpc_pkg::*;

  // Configuration registers
  logic [7:0]  magic_first_r, magic_second_r, format_version_r;
  logic        crc_enable_r;
  logic [15:0] payload_cap_r;
  logic [63:0] opcode_mask_r;

  // Frame state
  logic [16:0] byte_count_r, byte_count_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [15:0] len_r, len_nxt;
  logic [31:0] ts_r, ts_nxt;
  logic [7:0]  opc_r, opc_nxt;
  logic [2:0]  fault_r, fault_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic        verdict_r, verdict_nxt;

  // Output register
  logic        out_valid_r;
  out_t        out_data_r;
  out_t        res;
  logic        emit;

  logic        in_fire;
  logic        have, done;
  logic [2:0]  st;
  logic [16:0] pl_end;
  logic [7:0]  b;
  logic        eob;

  assign in_stall  = out_valid_r && out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign b      = in_data.rx_byte;
  assign eob    = in_data.end_of_buffer;
  assign pl_end = HDR_BYTES + {1'b0, len_r};

  // Per-byte parse, check and CRC update
  always_comb begin
    byte_count_nxt = byte_count_r;
    crc_nxt        = crc_r;
    seq_nxt        = seq_r;
    len_nxt        = len_r;
    ts_nxt         = ts_r;
    opc_nxt        = opc_r;
    fault_nxt      = fault_r;
    crc_lo_nxt     = crc_lo_r;
    verdict_nxt    = verdict_r;
    have           = 1'b0;
    done           = 1'b0;
    st             = ST_OK;
    res            = '0;

    if (!verdict_r) begin
      if (byte_count_r < HDR_BYTES) begin
        crc_nxt = crc_feed(crc_r, b);
        case (byte_count_r[3:0])
          OFS_MAGIC0: begin
            if (b != magic_first_r && fault_r == ST_OK) fault_nxt = ST_BAD_MAGIC;
          end
          OFS_MAGIC1: begin
            if (b != magic_second_r && fault_r == ST_OK) fault_nxt = ST_BAD_MAGIC;
          end
          OFS_VERSION: begin
            if (b != format_version_r && fault_r == ST_OK) fault_nxt = ST_BAD_VERSION;
          end
          OFS_OPCODE: begin
            opc_nxt = b;
            if (fault_r == ST_OK && (b[7:6] != 2'b00 || !opcode_mask_r[b[5:0]]))
              fault_nxt = ST_BAD_OPCODE;
          end
          OFS_SEQ_LO: seq_nxt[7:0]  = b;
          OFS_SEQ_HI: seq_nxt[15:8] = b;
          OFS_LEN_LO: len_nxt[7:0]  = b;
          OFS_LEN_HI: len_nxt[15:8] = b;
          // timestamp bytes, little-endian
          default: ts_nxt[{byte_count_r[1:0], 3'b000} +: 8] = b;
        endcase
        // last header byte: cap check and header verdict
        if (byte_count_r == HDR_LAST) begin
          if (fault_nxt == ST_OK && payload_cap_r != 16'd0 && len_r > payload_cap_r)
            fault_nxt = ST_OVER_CAP;
          if (fault_nxt != ST_OK) begin
            done = 1'b1;
            st   = fault_nxt;
          end else if (len_r == 16'd0 && !crc_enable_r) begin
            done = 1'b1;
            st   = ST_OK;
          end
        end
      end else if (byte_count_r < pl_end) begin
        // payload byte
        crc_nxt = crc_feed(crc_r, b);
        have    = 1'b1;
        if (byte_count_r == pl_end - 17'd1 && !crc_enable_r) begin
          done = 1'b1;
          st   = ST_OK;
        end
      end else if (byte_count_r == pl_end) begin
        crc_lo_nxt = b;
      end else begin
        done = 1'b1;
        st   = ({b, crc_lo_r} == crc_r) ? ST_OK : ST_BAD_CRC;
      end

      // buffer ended early: short header outranks a held header fault
      if (eob && (byte_count_r < HDR_LAST || !done)) begin
        done = 1'b1;
        st   = ST_TRUNCATED;
      end

      byte_count_nxt = byte_count_r + 17'd1;
      verdict_nxt    = done;
    end

    // Result item
    emit               = done || have;
    res.payload_byte   = have ? b : 8'd0;
    res.payload_valid  = have;
    res.payload_index  = have ? (byte_count_r[15:0] - HDR_BYTES[15:0]) : 16'd0;
    res.frame_done     = done;
    res.status         = done ? st : ST_OK;
    res.frame_opcode   = opc_nxt;
    res.sequence_res   = seq_nxt;
    res.timestamp_ms   = ts_nxt;
    res.payload_length = len_nxt;

    // End of buffer returns the frame state to reset
    if (eob) begin
      byte_count_nxt = '0;
      crc_nxt        = CRC_INIT;
      seq_nxt        = '0;
      len_nxt        = '0;
      ts_nxt         = '0;
      opc_nxt        = '0;
      fault_nxt      = ST_OK;
      crc_lo_nxt     = '0;
      verdict_nxt    = 1'b0;
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      crc_r        <= CRC_INIT;
      seq_r        <= '0;
      len_r        <= '0;
      ts_r         <= '0;
      opc_r        <= '0;
      fault_r      <= ST_OK;
      crc_lo_r     <= '0;
      verdict_r    <= 1'b0;
    end else if (in_fire) begin
      byte_count_r <= byte_count_nxt;
      crc_r        <= crc_nxt;
      seq_r        <= seq_nxt;
      len_r        <= len_nxt;
      ts_r         <= ts_nxt;
      opc_r        <= opc_nxt;
      fault_r      <= fault_nxt;
      crc_lo_r     <= crc_lo_nxt;
      verdict_r    <= verdict_nxt;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= emit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_data_r <= res;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_first_r    <= 8'd84;
      magic_second_r   <= 8'd67;
      format_version_r <= 8'd1;
      crc_enable_r     <= 1'b1;
      payload_cap_r    <= 16'd0;
      opcode_mask_r    <= 64'd62;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAGIC_FIRST:    magic_first_r    <= cfg_data[7:0];
        REG_MAGIC_SECOND:   magic_second_r   <= cfg_data[7:0];
        REG_FORMAT_VERSION: format_version_r <= cfg_data[7:0];
        REG_CRC_ENABLE:     crc_enable_r     <= cfg_data[0];
        REG_PAYLOAD_CAP:    payload_cap_r    <= cfg_data[15:0];
        REG_OPCODE_MASK:    opcode_mask_r    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/cfpc_checker.sv -----
// Port-level assertions for the framed packet checker core, bound to the core.
// Depends on cfpc_pkg and crc_framed_packet_checker_core_defines.svh.
`timescale 1ns / 1ps
`include "crc_framed_packet_checker_core_defines.svh"

module cfpc_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input cfpc_pkg::out_t out_data
);
  import cfpc_pkg::*;

  // payload fields read zero
  logic pay_zero;
  assign pay_zero = (out_data.payload_byte == 8'd0) && (out_data.payload_index == 16'd0);

  // a stalled result holds
  `CFPC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  // input backs up only behind a waiting result
  `CFPC_ASSERT_IMP(a_stall_cause, in_valid && in_stall, out_valid && out_stall)
  // every result carries a byte or a verdict
  `CFPC_ASSERT_IMP(a_res_content, out_valid, out_data.payload_valid || out_data.frame_done)
  // status only accompanies a verdict
  `CFPC_ASSERT_IMP(a_status_done, out_valid && !out_data.frame_done, out_data.status == ST_OK)
  // a verdict-only result has zeroed payload fields
  `CFPC_ASSERT_IMP(a_no_payload, out_valid && !out_data.payload_valid, pay_zero)

endmodule

bind crc_framed_packet_checker_core cfpc_checker u_cfpc_checker (.*);
